// ===== src/circle_elastic_collision_top_assert.svh =====
// Assertion macros shared by the collision pipeline.
// Both expect signals named clk and rst in the including module.
`ifndef CIRCLE_ELASTIC_COLLISION_TOP_ASSERT_SVH
`define CIRCLE_ELASTIC_COLLISION_TOP_ASSERT_SVH

// same-cycle implication
`define CEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision pipeline check failed");

// next-cycle implication
`define CEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collision pipeline check failed");

`endif

// ===== src/cec_pkg.sv =====
`timescale 1ns / 1ps
package cec_pkg;

  localparam int QW        = 36;   // quotient bits, magnitude stays below 2^34
  localparam int NW        = 106;  // dividend / remainder width
  localparam int DW        = 70;   // divisor width (twice the denominator)
  localparam int DIV_LANES = 4;    // first x, first y, second x, second y

  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
  } vel_t;

  typedef struct packed {
    logic touching;
    logic bounced;
    logic neg_x;
    logic neg_y;
    vel_t vel;
  } side_t;

endpackage

// ===== src/cec_div_pipe.sv =====
`timescale 1ns / 1ps
module cec_div_pipe import cec_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [DIV_LANES-1:0][NW-1:0]        in_numer,
  input  logic [DW-1:0]                       in_dvs,
  input  side_t                               in_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [DIV_LANES-1:0][QW-1:0]        out_quot,
  output side_t                               out_side
);

  // restoring division, one quotient bit per stage, MSB first
  logic [QW-1:0]                        vld;
  logic [QW:0]                          en;
  logic [QW-1:0][DIV_LANES-1:0][NW-1:0] rem;
  logic [QW-1:0][DIV_LANES-1:0][QW-1:0] quot;
  logic [QW-1:0][DW-1:0]                dvs;
  side_t                                side [QW];

  assign en[QW] = out_ready;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic                         src_valid;
    logic [DIV_LANES-1:0][NW-1:0] src_rem;
    logic [DIV_LANES-1:0][QW-1:0] src_quot;
    logic [DW-1:0]                src_dvs;
    side_t                        src_side;
    logic [NW-1:0]                shd;
    logic [DIV_LANES-1:0][NW-1:0] rem_next;
    logic [DIV_LANES-1:0][QW-1:0] quot_next;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_numer;
      assign src_quot  = '0;
      assign src_dvs   = in_dvs;
      assign src_side  = in_side;
    end else begin : g_rest
      assign src_valid = vld[k-1];
      assign src_rem   = rem[k-1];
      assign src_quot  = quot[k-1];
      assign src_dvs   = dvs[k-1];
      assign src_side  = side[k-1];
    end

    assign en[k] = ~vld[k] | en[k+1];
    assign shd   = NW'(src_dvs) << SH;

    always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
        if (src_rem[l] >= shd) begin
          rem_next[l]  = src_rem[l] - shd;
          quot_next[l] = {src_quot[l][QW-2:0], 1'b1};
        end else begin
          rem_next[l]  = src_rem[l];
          quot_next[l] = {src_quot[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= rem_next;
        quot[k] <= quot_next;
        dvs[k]  <= src_dvs;
        side[k] <= src_side;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[QW-1];
  assign out_quot  = quot[QW-1];
  assign out_side  = side[QW-1];

endmodule

// ===== src/circle_elastic_collision_top.sv =====
// Elastic collision of two circles, one ordered ball pair per transfer.
// Input channel in_valid/in_ready carries both balls (position, velocity,
// radius, mass); output channel out_valid/out_ready carries touching,
// bounced and the four updated velocities, saturated to 32 bits.
// Pipeline: six setup stages (differences, squares and dot-product terms,
// touch and approach tests with mass-weighted normals, multiplier partial
// products, sums, rounding offset), a 36-stage restoring divider that settles
// one quotient bit per stage, and the output register.
// Throughput: one pair per cycle; every stage is a register, so a new pair
// enters each cycle while out_ready is high.
// Stall: a stage holds when it is full and the next one holds; bubbles
// close up, so in_ready drops only when all stages hold data and out_ready is low.
// Reset (rst, synchronous) clears all stage valid bits; no data is kept.
`timescale 1ns / 1ps
module circle_elastic_collision_top import cec_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic        [23:0] first_radius,
  input  logic        [15:0] first_mass,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic        [23:0] second_radius,
  input  logic        [15:0] second_mass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               touching,
  output logic               bounced,
  output logic signed [31:0] new_first_vel_x,
  output logic signed [31:0] new_first_vel_y,
  output logic signed [31:0] new_second_vel_x,
  output logic signed [31:0] new_second_vel_y
);

  `include "circle_elastic_collision_top_assert.svh"

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647)       return 32'sh7fffffff;
    else if (v < -38'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
  logic div_in_ready, div_out_valid;
  logic [DIV_LANES-1:0][QW-1:0] div_quot;
  side_t div_side;

  // stage A: differences
  logic               a_vld;
  logic signed [32:0] a_dx, a_dy, a_dvx, a_dvy;
  logic        [24:0] a_rsum;
  logic               a_rnz;
  logic        [15:0] a_m1, a_m2;
  vel_t               a_vel;
  logic               both_zero;

  assign both_zero = (first_mass == '0) && (second_mass == '0);

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en_a) a_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_dx     <= 33'(first_pos_x) - 33'(second_pos_x);
      a_dy     <= 33'(first_pos_y) - 33'(second_pos_y);
      a_dvx    <= 33'(second_vel_x) - 33'(first_vel_x);
      a_dvy    <= 33'(second_vel_y) - 33'(first_vel_y);
      a_rsum   <= {1'b0, first_radius} + {1'b0, second_radius};
      a_rnz    <= (first_radius != '0) && (second_radius != '0);
      a_m1     <= both_zero ? 16'd1 : first_mass;
      a_m2     <= both_zero ? 16'd1 : second_mass;
      a_vel    <= '{v1x: first_vel_x, v1y: first_vel_y,
                    v2x: second_vel_x, v2y: second_vel_y};
    end
  end

  // stage B: magnitudes, squares, dot-product terms
  logic               b_vld;
  logic        [32:0] ax_w, ay_w;
  logic        [49:0] b_axsq, b_aysq, b_rsq;
  logic signed [58:0] b_pdx, b_pdy;
  logic        [24:0] b_ax, b_ay;
  logic               b_near, b_rnz, b_negx, b_negy;
  logic        [16:0] b_s, b_tm1, b_tm2;
  vel_t               b_vel;

  assign ax_w = a_dx[32] ? 33'(-a_dx) : a_dx;
  assign ay_w = a_dy[32] ? 33'(-a_dy) : a_dy;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en_b) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_axsq <= ax_w[24:0] * ax_w[24:0];
      b_aysq <= ay_w[24:0] * ay_w[24:0];
      b_rsq  <= a_rsum * a_rsum;
      // only meaningful when near: |dx| then fits 26 signed bits
      b_pdx  <= $signed(a_dx[25:0]) * a_dvx;
      b_pdy  <= $signed(a_dy[25:0]) * a_dvy;
      b_ax   <= ax_w[24:0];
      b_ay   <= ay_w[24:0];
      b_near <= (ax_w <= 33'(a_rsum)) && (ay_w <= 33'(a_rsum));
      b_rnz  <= a_rnz;
      b_negx <= a_dx[32];
      b_negy <= a_dy[32];
      b_s    <= 17'(a_m1) + 17'(a_m2);
      b_tm1  <= {a_m1, 1'b0};
      b_tm2  <= {a_m2, 1'b0};
      b_vel  <= a_vel;
    end
  end

  // stage C: length, touch and approach tests, mass-weighted normals
  logic               c_vld;
  logic        [50:0] len2_w;
  logic signed [59:0] dot_w;
  logic               touch_w;
  logic        [50:0] c_len2;
  logic        [59:0] c_dot;
  logic        [16:0] c_s;
  logic [DIV_LANES-1:0][41:0] c_a;
  side_t              c_side;

  assign len2_w  = 51'(b_axsq) + 51'(b_aysq);
  assign dot_w   = 60'(b_pdx) + 60'(b_pdy);
  assign touch_w = b_rnz && b_near && (len2_w <= 51'(b_rsq));

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en_c) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_len2 <= len2_w;
      c_dot  <= dot_w;
      c_s    <= b_s;
      c_a[0] <= b_ax * b_tm2;
      c_a[1] <= b_ay * b_tm2;
      c_a[2] <= b_ax * b_tm1;
      c_a[3] <= b_ay * b_tm1;
      c_side <= '{touching: touch_w,
                  bounced:  touch_w && !dot_w[59] && (dot_w != '0),
                  neg_x:    b_negx, neg_y: b_negy, vel: b_vel};
    end
  end

  // stage D: partial products
  logic        d_vld;
  logic [42:0] d_den_lo;
  logic [41:0] d_den_hi;
  logic [DIV_LANES-1:0][3:0][50:0] d_pp;
  side_t       d_side;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (en_d) d_vld <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_den_lo <= c_s * c_len2[25:0];
      d_den_hi <= c_s * c_len2[50:26];
      for (int l = 0; l < DIV_LANES; l++) begin
        d_pp[l][0] <= c_a[l][20:0]  * c_dot[29:0];
        d_pp[l][1] <= c_a[l][20:0]  * c_dot[59:30];
        d_pp[l][2] <= c_a[l][41:21] * c_dot[29:0];
        d_pp[l][3] <= c_a[l][41:21] * c_dot[59:30];
      end
      d_side <= c_side;
    end
  end

  // stage E: sum partials
  logic        e_vld;
  logic [67:0] e_den;
  logic [DIV_LANES-1:0][NW-1:0] e_num;
  side_t       e_side;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en_e) e_vld <= d_vld;
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_den <= 68'(d_den_lo) + (68'(d_den_hi) << 26);
      for (int l = 0; l < DIV_LANES; l++) begin
        e_num[l] <= NW'(d_pp[l][0]) + (NW'(d_pp[l][1]) << 30)
                  + (NW'(d_pp[l][2]) << 21) + (NW'(d_pp[l][3]) << 51);
      end
      e_side <= d_side;
    end
  end

  // stage F: rounding offset, (2n + d) / 2d gives round half away
  logic          f_vld;
  logic [DW-1:0] f_dvs;
  logic [DIV_LANES-1:0][NW-1:0] f_numer;
  side_t         f_side;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en_f) f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      f_dvs <= DW'(e_den) << 1;
      for (int l = 0; l < DIV_LANES; l++) begin
        f_numer[l] <= (e_num[l] << 1) + NW'(e_den);
      end
      f_side <= e_side;
    end
  end

  cec_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .in_ready  (div_in_ready),
    .in_numer  (f_numer),
    .in_dvs    (f_dvs),
    .in_side   (f_side),
    .out_valid (div_out_valid),
    .out_ready (en_g),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // stage G: apply signed deltas, saturate, output register
  logic               g_vld;
  logic signed [37:0] dq [DIV_LANES];
  logic signed [37:0] s1x, s1y, s2x, s2y;

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      logic neg;
      neg   = (l % 2 == 0) ? div_side.neg_x : div_side.neg_y;
      dq[l] = neg ? -$signed({2'b00, div_quot[l]}) : $signed({2'b00, div_quot[l]});
    end
    s1x = 38'(div_side.vel.v1x) + dq[0];
    s1y = 38'(div_side.vel.v1y) + dq[1];
    s2x = 38'(div_side.vel.v2x) - dq[2];
    s2y = 38'(div_side.vel.v2y) - dq[3];
  end

  assign en_f = ~f_vld | div_in_ready;
  assign en_e = ~e_vld | en_f;
  assign en_d = ~d_vld | en_e;
  assign en_c = ~c_vld | en_d;
  assign en_b = ~b_vld | en_c;
  assign en_a = ~a_vld | en_b;
  assign en_g = ~g_vld | out_ready;

  always_ff @(posedge clk) begin
    if (rst) g_vld <= 1'b0;
    else if (en_g) g_vld <= div_out_valid;
  end

  always_ff @(posedge clk) begin
    if (en_g) begin
      touching <= div_side.touching;
      bounced  <= div_side.bounced;
      if (div_side.bounced) begin
        new_first_vel_x  <= sat32(s1x);
        new_first_vel_y  <= sat32(s1y);
        new_second_vel_x <= sat32(s2x);
        new_second_vel_y <= sat32(s2y);
      end else begin
        new_first_vel_x  <= div_side.vel.v1x;
        new_first_vel_y  <= div_side.vel.v1y;
        new_second_vel_x <= div_side.vel.v2x;
        new_second_vel_y <= div_side.vel.v2y;
      end
    end
  end

  assign in_ready  = en_a;
  assign out_valid = g_vld;

  `CEC_ASSERT_IMP(a_bounce_needs_touch, out_valid && bounced, touching)
  `CEC_ASSERT_IMP(a_stall_only_when_full, !in_ready, out_valid && !out_ready)
  `CEC_ASSERT_IMP(a_bounce_len_nonzero, c_vld && c_side.bounced, c_len2 != '0)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import cec_pkg::*;

  typedef struct {
    logic signed [31:0] p1x, p1y, v1x, v1y;
    logic        [23:0] r1;
    logic        [15:0] m1;
    logic signed [31:0] p2x, p2y, v2x, v2y;
    logic        [23:0] r2;
    logic        [15:0] m2;
  } pair_t;

  typedef struct {
    logic touch, bounce;
    logic signed [31:0] u1x, u1y, u2x, u2y;
  } outcome_t;

  typedef struct {
    pair_t    p;
    logic     known;
    outcome_t o;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic signed [31:0] first_pos_x = 0, first_pos_y = 0, first_vel_x = 0, first_vel_y = 0;
  logic        [23:0] first_radius = 0;
  logic        [15:0] first_mass = 0;
  logic signed [31:0] second_pos_x = 0, second_pos_y = 0, second_vel_x = 0, second_vel_y = 0;
  logic        [23:0] second_radius = 0;
  logic        [15:0] second_mass = 0;
  logic touching, bounced;
  logic signed [31:0] new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y;

  circle_elastic_collision_top dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  outcome_t pending_q[$];
  int errors = 0, checked = 0, bounces = 0, touches = 0;
  int send_idle = 0, recv_idle = 0;
  bit sending_done = 0;

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round(num/den), ties away from zero, den > 0
  function automatic logic signed [127:0] round_div(logic signed [127:0] num,
                                                    logic signed [127:0] den);
    logic signed [127:0] a, q;
    a = num < 0 ? -num : num;
    q = (2 * a + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic outcome_t collide(pair_t p);
    outcome_t o;
    logic signed [127:0] dx, dy, rs, len2, dot, m1, m2, den;
    o.touch = 0; o.bounce = 0;
    o.u1x = p.v1x; o.u1y = p.v1y; o.u2x = p.v2x; o.u2y = p.v2y;
    dx = 128'(p.p1x) - 128'(p.p2x);
    dy = 128'(p.p1y) - 128'(p.p2y);
    rs = 128'(p.r1) + 128'(p.r2);
    len2 = dx * dx + dy * dy;
    if (p.r1 != 0 && p.r2 != 0 && len2 <= rs * rs) o.touch = 1;
    if (o.touch) begin
      dot = dx * (128'(p.v2x) - 128'(p.v1x)) + dy * (128'(p.v2y) - 128'(p.v1y));
      if (dot > 0) begin
        o.bounce = 1;
        m1 = p.m1; m2 = p.m2;
        if (m1 == 0 && m2 == 0) begin
          m1 = 1; m2 = 1;
        end
        den = (m1 + m2) * len2;
        o.u1x = clamp32(128'(p.v1x) + round_div(2 * m2 * dot * dx, den));
        o.u1y = clamp32(128'(p.v1y) + round_div(2 * m2 * dot * dy, den));
        o.u2x = clamp32(128'(p.v2x) - round_div(2 * m1 * dot * dx, den));
        o.u2y = clamp32(128'(p.v2y) - round_div(2 * m1 * dot * dy, den));
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    errors++;
    $display("mismatch result %0d %s: got %0d want %0d", checked, what, got, want);
  endtask

  task automatic send_pair(pair_t p);
    while (($urandom % 100) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    first_pos_x <= p.p1x; first_pos_y <= p.p1y;
    first_vel_x <= p.v1x; first_vel_y <= p.v1y;
    first_radius <= p.r1; first_mass <= p.m1;
    second_pos_x <= p.p2x; second_pos_y <= p.p2y;
    second_vel_x <= p.v2x; second_vel_y <= p.v2y;
    second_radius <= p.r2; second_mass <= p.m2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  // mostly near pairs, most of them approaching, plus some far-apart pairs
  function automatic pair_t rand_pair();
    pair_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p.p1x = rand_coord(); p.p1y = rand_coord();
    p.v1x = rand_coord(); p.v1y = rand_coord();
    p.v2x = rand_coord(); p.v2y = rand_coord();
    p.r1 = (sel == 0) ? 24'($urandom) : 24'($urandom_range(1, 24'h0fffff));
    p.r2 = (sel == 1) ? 24'($urandom) : 24'($urandom_range(1, 24'h0fffff));
    if ($urandom_range(0, 19) == 0) p.r1 = 0;
    p.m1 = 16'($urandom); p.m2 = 16'($urandom);
    if ($urandom_range(0, 9) == 0) p.m1 = 0;
    if ($urandom_range(0, 9) == 0) p.m2 = 0;
    if (sel < 8) begin
      p.p2x = p.p1x + $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
      p.p2y = p.p1y + $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
      if (sel < 6) begin
        p.v2x = p.v1x + (p.p1x - p.p2x) / 4;
        p.v2y = p.v1y + (p.p1y - p.p2y) / 4;
      end
    end else begin
      p.p2x = $urandom; p.p2y = $urandom;
    end
    return p;
  endfunction

  function automatic row_t mk(int p1x, int p1y, int v1x, int v1y, int r1, int m1,
                              int p2x, int p2y, int v2x, int v2y, int r2, int m2,
                              bit known = 0, bit t = 0, bit b = 0);
    row_t r;
    r.p = '{p1x, p1y, v1x, v1y, 24'(r1), 16'(m1), p2x, p2y, v2x, v2y, 24'(r2), 16'(m2)};
    r.known = known;
    r.o = '{t, b, v1x, v1y, v2x, v2y};
    return r;
  endfunction

  localparam int ONE = 32'h10000;
  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;

  row_t directed[$];

  initial begin
    outcome_t want;
    directed = '{
      // empty slot passes velocities through
      mk(0, 0, ONE, -ONE, 0, 1, 0, 0, 3, 4, ONE, 1, 1, 0, 0),
      mk(0, 0, MAXI, MINI, ONE, 1, 0, 0, MINI, MAXI, 0, 1, 1, 0, 0),
      // touching, separating
      mk(0, 0, -ONE, 0, ONE, 1, 2 * ONE, 0, ONE, 0, ONE, 1, 1, 1, 0),
      // far apart, extremes of position
      mk(MAXI, MAXI, 5, 6, 24'hffffff, 65535, MINI, MINI, 7, 8, 24'hffffff, 65535, 1, 0, 0),
      // equal masses head on, then unequal masses at an angle
      mk(0, 0, ONE, 0, ONE, 1, 2 * ONE, 0, -ONE, 0, ONE, 1),
      mk(0, 0, ONE, ONE, ONE, 5, ONE, ONE, -ONE, 0, ONE, 3),
      // both masses zero, one mass zero
      mk(0, 0, ONE, 0, ONE, 0, ONE, 0, 0, 0, ONE, 0),
      mk(0, 0, ONE, 0, ONE, 0, ONE, 0, 0, 0, ONE, 9),
      mk(0, 0, ONE, 0, ONE, 9, ONE, 0, 0, 0, ONE, 0),
      // saturating results
      mk(0, 0, MAXI, MAXI, ONE, 1, 1, 1, MINI, MINI, ONE, 65535),
      mk(0, 0, MINI, MINI, 24'hffffff, 65535, -1, -1, MAXI, MAXI, 24'hffffff, 1),
      // same centre, touching exactly at rsum and just beyond it, extreme radii and positions
      mk(5, 5, ONE, 0, 1, 1, 5, 5, -ONE, 0, 1, 1, 1, 1, 0),
      mk(0, 0, 0, 0, 1, 2, 2, 0, -1, 0, 1, 2),
      mk(0, 0, 0, 0, 1, 2, 3, 0, -1, 0, 1, 2, 1, 0, 0),
      mk(0, -ONE, 3, ONE, 24'hffffff, 65535, 24'h1000, 24'h1000, -ONE, -3, 24'hffffff, 1),
      mk(MINI, MINI, 0, 0, ONE, 7, MINI + 1, MINI + 1, -ONE, -ONE, ONE, 65535)
    };
    repeat (7) @(posedge clk);
    rst <= 0;
    for (int i = 0; i < directed.size(); i++) begin
      want = directed[i].known ? directed[i].o : collide(directed[i].p);
      pending_q.push_back(want);
      send_pair(directed[i].p);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 14 : ph == 1 ? 83 : 0;
      recv_idle = ph == 0 ? 83 : ph == 1 ? 14 : 0;
      for (int i = 0; i < 610; i++) begin
        pair_t p;
        p = rand_pair();
        pending_q.push_back(collide(p));
        send_pair(p);
      end
    end
    in_valid <= 0;
    sending_done = 1;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom % 100) >= recv_idle;
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("unexpected result transfer");
      end else begin
        w = pending_q.pop_front();
        if (touching !== w.touch)
          report_mismatch("touching", 32'(touching), 32'(w.touch));
        if (bounced !== w.bounce)
          report_mismatch("bounced", 32'(bounced), 32'(w.bounce));
        if (new_first_vel_x !== w.u1x) report_mismatch("first vx", new_first_vel_x, w.u1x);
        if (new_first_vel_y !== w.u1y) report_mismatch("first vy", new_first_vel_y, w.u1y);
        if (new_second_vel_x !== w.u2x) report_mismatch("second vx", new_second_vel_x, w.u2x);
        if (new_second_vel_y !== w.u2y) report_mismatch("second vy", new_second_vel_y, w.u2y);
        touches += w.touch;
        bounces += w.bounce;
      end
      checked++;
    end
  end

  initial begin
    wait (sending_done);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("checked %0d ball pairs: %0d touching, %0d bounced", checked, touches, bounces);
    $display("directed edge cases plus random pairs under three stall patterns");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end
endmodule
